FILE: hdl/assert_macros.svh
// Assertion macros used by the allocator module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// A condition that implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: hdl/eida_pkg.sv
`default_nettype none

package eida_pkg;

  // Request kinds.
  localparam logic [3:0] KIND_ALLOC   = 4'd0;
  localparam logic [3:0] KIND_RUN     = 4'd1;
  localparam logic [3:0] KIND_FREE    = 4'd2;
  localparam logic [3:0] KIND_SET     = 4'd3;
  localparam logic [3:0] KIND_CLEAR   = 4'd4;
  localparam logic [3:0] KIND_ZERO    = 4'd5;
  localparam logic [3:0] KIND_READ    = 4'd6;
  localparam logic [3:0] KIND_CHECK   = 4'd7;
  localparam logic [3:0] KIND_COUNT   = 4'd8;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD_ID  = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] entity_id;
    logic [4:0]  component_type;
    logic [6:0]  run_length;
  } req_t;

  typedef struct packed {
    logic [9:0]  given_id;
    logic [31:0] mask_out;
    logic        is_live;
    logic [10:0] live_total;
    logic [1:0]  status;
    logic        last;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/eida_ram.sv
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data.
module eida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/eida_front.sv
`default_nettype none

// Front end: takes request beats into a two-entry queue for the back end.
module eida_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire eida_pkg::req_t in_data,
  output logic                q_valid,
  output eida_pkg::req_t      q_data,
  input  wire logic           q_take
);

  eida_pkg::req_t slot_r [2];
  logic           rd_ptr_r, wr_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_take) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/entity_id_allocator_with_masks.sv
`default_nettype none
// Channel  | ports                         | beat
// request  | in_valid, in_stall, in_data   | one request
// result   | out_valid, out_stall, out_data| one result item
// A single request passes through the back end in order: take, memory read,
// execute with write-back, and the result beat.
// A granted run gives one result beat per ID, each set by the free-list read
// before its grant; no new request is taken until the last beat.
// After reset a clearing pass fills the free list and
// clears the masks and live bits; requests are held off until it ends.
// A stalled result holds the back end; the front queue still takes two beats.

`include "assert_macros.svh"

module entity_id_allocator_with_masks #(
  parameter int CAPACITY  = 1024,
  parameter int MASK_BITS = 32,
  parameter int MAX_RUN   = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire eida_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output eida_pkg::rsp_t      out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_LOOK, S_EXEC, S_RUNRD, S_RUNWAIT, S_RUNGO, S_OUT
  } state_t;

  state_t         state_r;
  logic [AW-1:0]  init_r;
  eida_pkg::req_t req_r;
  logic [AW-1:0]  head_r, tail_r;
  logic [CW-1:0]  free_r, live_r;
  logic [6:0]     left_r;
  eida_pkg::rsp_t rsp_r, rsp_nxt;
  logic           q_valid, q_take;
  eida_pkg::req_t q_data;

  // Memories: entry word {live, mask}, and the free list.
  logic                 ent_we, fq_we;
  logic [AW-1:0]        ent_wa, ent_ra, fq_wa, fq_ra;
  logic [MASK_BITS:0]   ent_wd, ent_rd;
  logic [AW-1:0]        fq_wd, fq_rd;

  eida_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
  );

  eida_ram #(.WIDTH(MASK_BITS + 1), .DEPTH(CAPACITY)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra),
    .rdata(ent_rd)
  );

  eida_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_fq (
    .clk(clk), .we(fq_we), .waddr(fq_wa), .wdata(fq_wd), .raddr(fq_ra),
    .rdata(fq_rd)
  );

  assign q_take    = (state_r == S_IDLE) && q_valid;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = rsp_r;

  // Decode of the held request.
  logic          id_in;
  logic [AW-1:0] rid;
  logic          ok;
  logic          bit_in;
  logic [6:0]    run_sat;
  logic [MASK_BITS-1:0] cur_mask, one_hot;

  assign id_in   = ({16'd0, req_r.entity_id} < 32'(CAPACITY));
  assign rid     = req_r.entity_id[AW-1:0];
  assign ok      = id_in && ent_rd[MASK_BITS];
  assign bit_in  = ({27'd0, req_r.component_type} < 32'(MASK_BITS));
  assign run_sat = (req_r.run_length > 7'(MAX_RUN)) ? 7'(MAX_RUN) : req_r.run_length;
  assign cur_mask = ent_rd[MASK_BITS-1:0];
  assign one_hot  = MASK_BITS'(1) << req_r.component_type;

  function automatic logic [31:0] ext(input logic [MASK_BITS-1:0] m);
    logic [63:0] w;
    w = 64'(m);
    return w[31:0];
  endfunction

  // Memory port control.
  always_comb begin
    ent_we = 1'b0; ent_wa = rid; ent_wd = '0; ent_ra = rid;
    fq_we = 1'b0; fq_wa = tail_r; fq_wd = rid; fq_ra = head_r;
    unique case (state_r)
      S_INIT: begin
        ent_we = 1'b1; ent_wa = init_r;
        fq_we = 1'b1; fq_wa = init_r; fq_wd = init_r;
      end
      S_IDLE: ent_ra = q_data.entity_id[AW-1:0];
      S_EXEC: begin
        unique case (req_r.kind)
          eida_pkg::KIND_ALLOC: begin
            ent_we = (free_r != '0); ent_wa = fq_rd; ent_wd = {1'b1, {MASK_BITS{1'b0}}};
          end
          eida_pkg::KIND_FREE: begin
            ent_we = ok; fq_we = ok;
          end
          eida_pkg::KIND_SET: begin
            ent_we = ok && bit_in; ent_wd = {1'b1, cur_mask | one_hot};
          end
          eida_pkg::KIND_CLEAR: begin
            ent_we = ok && bit_in; ent_wd = {1'b1, cur_mask & ~one_hot};
          end
          eida_pkg::KIND_ZERO: begin
            ent_we = ok; ent_wd = {1'b1, {MASK_BITS{1'b0}}};
          end
          default: ;
        endcase
      end
      S_RUNGO: begin
        ent_we = 1'b1; ent_wa = fq_rd; ent_wd = {1'b1, {MASK_BITS{1'b0}}};
      end
      default: ;
    endcase
  end

  // Result beat of a single request, formed in the execute cycle.
  always_comb begin
    rsp_nxt.last       = 1'b1;
    rsp_nxt.given_id   = req_r.entity_id[9:0];
    rsp_nxt.mask_out   = '0;
    rsp_nxt.is_live    = 1'b0;
    rsp_nxt.status     = eida_pkg::ST_OK;
    rsp_nxt.live_total = 11'(live_r);
    unique case (req_r.kind)
      eida_pkg::KIND_ALLOC: begin
        if (free_r == '0) begin
          rsp_nxt.given_id = '0;
          rsp_nxt.status   = eida_pkg::ST_NO_FREE;
        end else begin
          rsp_nxt.given_id   = 10'(fq_rd);
          rsp_nxt.is_live    = 1'b1;
          rsp_nxt.live_total = 11'(live_r + CW'(1));
        end
      end
      eida_pkg::KIND_RUN: begin
        rsp_nxt.given_id = '0;
        if (run_sat != '0 && 32'(run_sat) > 32'(free_r)) begin
          rsp_nxt.status = eida_pkg::ST_NO_FREE;
        end
      end
      eida_pkg::KIND_FREE: begin
        if (!ok) rsp_nxt.status = eida_pkg::ST_BAD_ID;
        else rsp_nxt.live_total = 11'(live_r - CW'(1));
      end
      eida_pkg::KIND_SET, eida_pkg::KIND_CLEAR: begin
        if (!ok) rsp_nxt.status = eida_pkg::ST_BAD_ID;
        else begin
          rsp_nxt.is_live = 1'b1;
          if (!bit_in) begin
            rsp_nxt.status   = eida_pkg::ST_BAD_ID;
            rsp_nxt.mask_out = ext(cur_mask);
          end else if (req_r.kind == eida_pkg::KIND_SET) begin
            rsp_nxt.mask_out = ext(cur_mask | one_hot);
          end else begin
            rsp_nxt.mask_out = ext(cur_mask & ~one_hot);
          end
        end
      end
      eida_pkg::KIND_ZERO: begin
        if (!ok) rsp_nxt.status = eida_pkg::ST_BAD_ID;
        else rsp_nxt.is_live = 1'b1;
      end
      eida_pkg::KIND_READ: begin
        if (!ok) rsp_nxt.status = eida_pkg::ST_BAD_ID;
        else begin
          rsp_nxt.is_live  = 1'b1;
          rsp_nxt.mask_out = ext(cur_mask);
        end
      end
      eida_pkg::KIND_CHECK: begin
        rsp_nxt.is_live  = ok;
        rsp_nxt.mask_out = ok ? ext(cur_mask) : 32'd0;
      end
      default: rsp_nxt.given_id = '0;
    endcase
  end

  logic [AW-1:0] head_inc, tail_inc;
  assign head_inc = (32'(head_r) + 1 >= CAPACITY) ? '0 : head_r + AW'(1);
  assign tail_inc = (32'(tail_r) + 1 >= CAPACITY) ? '0 : tail_r + AW'(1);

  // Sequencer: state, pointers, counts and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      free_r  <= CW'(CAPACITY);
      live_r  <= '0;
      left_r  <= '0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          init_r <= init_r + AW'(1);
          if (32'(init_r) == CAPACITY - 1) state_r <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          req_r   <= q_data;
          state_r <= S_LOOK;
        end
        S_LOOK: state_r <= S_EXEC;
        S_EXEC: begin
          rsp_r <= rsp_nxt;
          unique case (req_r.kind)
            eida_pkg::KIND_ALLOC: begin
              state_r <= S_OUT;
              if (free_r != '0) begin
                head_r <= head_inc;
                free_r <= free_r - CW'(1);
                live_r <= live_r + CW'(1);
              end
            end
            eida_pkg::KIND_RUN: begin
              if (run_sat != '0 && 32'(run_sat) <= 32'(free_r)) begin
                left_r  <= run_sat;
                state_r <= S_RUNWAIT;
              end else begin
                state_r <= S_OUT;
              end
            end
            eida_pkg::KIND_FREE: begin
              state_r <= S_OUT;
              if (ok) begin
                tail_r <= tail_inc;
                free_r <= free_r + CW'(1);
                live_r <= live_r - CW'(1);
              end
            end
            default: state_r <= S_OUT;
          endcase
        end
        // Run: the free-list read at head_r comes back through the RAM's read register before RUNGO grants.
        S_RUNRD: state_r <= S_RUNWAIT;
        S_RUNWAIT: state_r <= S_RUNGO;
        S_RUNGO: begin
          rsp_r.given_id   <= 10'(fq_rd);
          rsp_r.mask_out   <= '0;
          rsp_r.is_live    <= 1'b1;
          rsp_r.status     <= eida_pkg::ST_OK;
          rsp_r.live_total <= 11'(live_r + CW'(1));
          rsp_r.last       <= (left_r == 7'd1);
          head_r  <= head_inc;
          free_r  <= free_r - CW'(1);
          live_r  <= live_r + CW'(1);
          left_r  <= left_r - 7'd1;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          state_r <= (left_r != '0) ? S_RUNRD : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_count_sum, clk, rst_n, state_r != S_INIT,
    32'(free_r) + 32'(live_r) == CAPACITY, "free and live counts disagree")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_IMPLY(a_no_take_init, clk, rst_n, state_r == S_INIT,
    !q_take, "request taken during clearing pass")

endmodule

`default_nettype wire
